@@ rtl/cmap_segment_glyph_lookup_defines.svh @@
// Assertion macros for the glyph lookup checker
`ifndef CMAP_SEGMENT_GLYPH_LOOKUP_DEFINES_SVH
`define CMAP_SEGMENT_GLYPH_LOOKUP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define CSGL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CSGL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/csgl_pkg.sv @@
// Types and constants for the cmap segment glyph lookup block
package csgl_pkg;

    localparam int SEG_MAX = 64;
    localparam int SEG_AW  = (SEG_MAX > 1) ? $clog2(SEG_MAX) : 1;
    localparam int CNT_W   = $clog2(SEG_MAX + 1);
    localparam int CFG_W   = 7;
    localparam int LIM_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [1:0] ST_MAPPED   = 2'd0;
    localparam logic [1:0] ST_UNMAPPED = 2'd1;
    localparam logic [1:0] ST_UNSUPP   = 2'd2;

    typedef struct packed {
        logic        op;
        logic [5:0]  seg_index;
        logic [15:0] end_code;
        logic [15:0] start_code;
        logic [15:0] id_delta;
        logic [15:0] id_range_offset;
        logic [15:0] code;
    } in_word_t;

    typedef struct packed {
        logic [15:0] glyph_index;
        logic [1:0]  status;
        logic [5:0]  matched_segment;
    } out_word_t;

    typedef struct packed {
        logic [15:0] end_code;
        logic [15:0] start_code;
        logic [15:0] delta;
        logic        indirect;
    } seg_entry_t;

    typedef struct packed {
        logic        hit;
        logic [1:0]  status;
        logic [15:0] glyph;
    } eval_t;

endpackage

@@ rtl/csgl_seg_ram.sv @@
// Segment table memory: one write port, one registered read port
module csgl_seg_ram (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [csgl_pkg::SEG_AW-1:0]  wr_addr,
    input  csgl_pkg::seg_entry_t         wr_data,
    input  logic                         rd_en,
    input  logic [csgl_pkg::SEG_AW-1:0]  rd_addr,
    output csgl_pkg::seg_entry_t         rd_data
);

    csgl_pkg::seg_entry_t mem [csgl_pkg::SEG_MAX];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/csgl_seg_eval.sv @@
// Compare and add unit: tests one segment entry against the code
module csgl_seg_eval (
    input  csgl_pkg::seg_entry_t entry,
    input  logic [15:0]          code,
    output csgl_pkg::eval_t      res
);

    always_comb
    begin
        res.hit    = (entry.end_code >= code);
        res.status = csgl_pkg::ST_MAPPED;
        res.glyph  = 16'd0;
        if (entry.start_code > code)
        begin
            res.status = csgl_pkg::ST_UNMAPPED;
        end
        else if (entry.indirect)
        begin
            res.status = csgl_pkg::ST_UNSUPP;
        end
        else
        begin
            res.glyph = entry.delta + code;   // wraps mod 65536
        end
    end

endmodule

@@ rtl/cmap_segment_glyph_lookup.sv @@
// Top level: segment scan sequencer around the table RAM and compare unit
// Write word: ready stays high after a write, so writes can follow back to back.
// Lookup word: entries are read in order, each compared against the code while the next is
//   read, up to the deciding one (at most min(segment_count, 64) entries); ready returns
//   once the result goes to the output, later while an earlier result still waits on out_ready.
// Reset: sequencer idle, no result pending, segment_count 0; table contents undefined.
module cmap_segment_glyph_lookup (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [6:0]            cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  csgl_pkg::in_word_t    in_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output csgl_pkg::out_word_t   out_word
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    localparam int CNT_W  = csgl_pkg::CNT_W;
    localparam int SEG_AW = csgl_pkg::SEG_AW;
    localparam int LIM_W  = csgl_pkg::LIM_W;

    logic [1:0]              state_reg, state_next;
    logic [6:0]              cnt_reg, cnt_next;
    logic                    out_vld_reg, out_vld_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic [15:0]             code_reg, code_next;
    logic [CNT_W-1:0]        limit_reg, limit_next;
    logic [CNT_W-1:0]        rd_idx_reg, rd_idx_next;
    logic [SEG_AW-1:0]       cmp_idx_reg, cmp_idx_next;
    csgl_pkg::out_word_t     res_reg, res_next;
    csgl_pkg::out_word_t     out_word_reg, out_word_next;

    logic                    in_acc;
    logic                    wr_en;
    logic                    issue;
    logic [LIM_W-1:0]        cnt_ext;
    logic [CNT_W-1:0]        limit_sat;
    csgl_pkg::seg_entry_t    wr_data;
    csgl_pkg::seg_entry_t    rd_data;
    csgl_pkg::eval_t         ev;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_acc    = in_valid && in_ready;
    assign out_valid = out_vld_reg;
    assign out_word  = out_word_reg;

    // writes past capacity are dropped
    assign wr_en = in_acc && (in_word.op == csgl_pkg::OP_WRITE)
                   && (LIM_W'(in_word.seg_index) < LIM_W'(csgl_pkg::SEG_MAX));

    assign wr_data.end_code   = in_word.end_code;
    assign wr_data.start_code = in_word.start_code;
    assign wr_data.delta      = in_word.id_delta;
    assign wr_data.indirect   = (in_word.id_range_offset != 16'd0);

    assign cnt_ext   = LIM_W'(cnt_reg);
    assign limit_sat = (cnt_ext > LIM_W'(csgl_pkg::SEG_MAX)) ? CNT_W'(csgl_pkg::SEG_MAX)
                                                             : CNT_W'(cnt_ext);

    assign issue = (state_reg == S_SCAN) && (rd_idx_reg < limit_reg);

    csgl_seg_ram u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (SEG_AW'(in_word.seg_index)),
        .wr_data (wr_data),
        .rd_en   (issue),
        .rd_addr (SEG_AW'(rd_idx_reg)),
        .rd_data (rd_data)
    );

    csgl_seg_eval u_eval (
        .entry (rd_data),
        .code  (code_reg),
        .res   (ev)
    );

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cfg_we ? cfg_wdata : cnt_reg;
        out_vld_next  = out_vld_reg;
        cmp_vld_next  = cmp_vld_reg;
        code_next     = code_reg;
        limit_next    = limit_reg;
        rd_idx_next   = rd_idx_reg;
        cmp_idx_next  = cmp_idx_reg;
        res_next      = res_reg;
        out_word_next = out_word_reg;

        if (out_vld_reg && out_ready)
        begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (in_word.op == csgl_pkg::OP_LOOKUP))
                begin
                    code_next    = in_word.code;
                    limit_next   = limit_sat;
                    rd_idx_next  = '0;
                    cmp_vld_next = 1'b0;
                    state_next   = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // read of entry i overlaps compare of entry i-1
                cmp_vld_next = issue;
                cmp_idx_next = SEG_AW'(rd_idx_reg);
                if (issue)
                begin
                    rd_idx_next = rd_idx_reg + CNT_W'(1);
                end
                if (cmp_vld_reg && ev.hit)
                begin
                    res_next.glyph_index     = ev.glyph;
                    res_next.status          = ev.status;
                    res_next.matched_segment = 6'(cmp_idx_reg);
                    state_next               = S_DONE;
                end
                else if (!issue)
                begin
                    res_next.glyph_index     = 16'd0;
                    res_next.status          = csgl_pkg::ST_UNMAPPED;
                    res_next.matched_segment = 6'd0;
                    state_next               = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_vld_reg || out_ready)
                begin
                    out_word_next = res_reg;
                    out_vld_next  = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
            cmp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
            cmp_vld_reg <= cmp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg     <= code_next;
        limit_reg    <= limit_next;
        rd_idx_reg   <= rd_idx_next;
        cmp_idx_reg  <= cmp_idx_next;
        res_reg      <= res_next;
        out_word_reg <= out_word_next;
    end

endmodule

@@ rtl/csgl_checker.sv @@
// Port-level checker for the glyph lookup block, bound to the top level
`include "cmap_segment_glyph_lookup_defines.svh"

module csgl_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  cfg_we,
    input logic [6:0]            cfg_wdata,
    input logic                  in_valid,
    input logic                  in_ready,
    input csgl_pkg::in_word_t    in_word,
    input logic                  out_valid,
    input logic                  out_ready,
    input csgl_pkg::out_word_t   out_word
);

    `CSGL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word), "result word dropped or changed while stalled")

    `CSGL_ASSERT_NOW(a_glyph_zero, out_valid && (out_word.status != csgl_pkg::ST_MAPPED), out_word.glyph_index == 16'd0, "glyph nonzero on a result that is not mapped")

    `CSGL_ASSERT_NEXT(a_lookup_busy, in_valid && in_ready && (in_word.op == csgl_pkg::OP_LOOKUP), !in_ready, "ready right after taking a lookup word")

    `CSGL_ASSERT_NEXT(a_write_quick, in_valid && in_ready && (in_word.op == csgl_pkg::OP_WRITE), in_ready, "write word did not finish in one cycle")

endmodule

bind cmap_segment_glyph_lookup csgl_checker u_csgl_checker (.*);

@@ sim/tb_cmap_segment_glyph_lookup.sv @@
// Testbench for cmap_segment_glyph_lookup: directed and random segment loads and lookups
module tb_cmap_segment_glyph_lookup;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = 80;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [6:0]           cfg_wdata;
    logic                 in_valid;
    logic                 in_ready;
    csgl_pkg::in_word_t   in_word;
    logic                 out_valid;
    logic                 out_ready;
    csgl_pkg::out_word_t  out_word;

    // shadow copy of the segment table and the scan count
    logic [15:0] seg_end      [csgl_pkg::SEG_MAX];
    logic [15:0] seg_start    [csgl_pkg::SEG_MAX];
    logic [15:0] seg_delta    [csgl_pkg::SEG_MAX];
    logic        seg_indirect [csgl_pkg::SEG_MAX];
    logic [6:0]  seg_count;

    csgl_pkg::out_word_t expected_glyphs [$];
    csgl_pkg::out_word_t glyph_want;

    int fail_count  = 0;
    int cycle_count = 0;
    int stall_left  = 0;
    bit gaps_on     = 1'b1;
    bit stalls_on   = 1'b1;

    cmap_segment_glyph_lookup u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // first segment whose end reaches the code decides the lookup
    function automatic csgl_pkg::out_word_t predict_glyph(input logic [15:0] code);
        csgl_pkg::out_word_t r;
        int                  scan_lim;
        bit                  decided;
        r               = '0;
        r.status        = csgl_pkg::ST_UNMAPPED;
        decided         = 1'b0;
        scan_lim        = (seg_count > csgl_pkg::SEG_MAX) ? csgl_pkg::SEG_MAX : seg_count;
        for (int i = 0; i < scan_lim; i++)
        begin
            if (!decided && seg_end[i] >= code)
            begin
                decided           = 1'b1;
                r.matched_segment = 6'(i);
                if (seg_start[i] > code)
                    r.status = csgl_pkg::ST_UNMAPPED;
                else if (seg_indirect[i])
                    r.status = csgl_pkg::ST_UNSUPP;
                else
                begin
                    r.status      = csgl_pkg::ST_MAPPED;
                    r.glyph_index = seg_delta[i] + code;
                end
            end
        end
        return r;
    endfunction

    function automatic csgl_pkg::in_word_t make_write(input int idx, input int e, input int s,
                                                      input int d, input int off);
        csgl_pkg::in_word_t w;
        w                 = '0;
        w.op              = csgl_pkg::OP_WRITE;
        w.seg_index       = 6'(idx);
        w.end_code        = 16'(e);
        w.start_code      = 16'(s);
        w.id_delta        = 16'(d);
        w.id_range_offset = 16'(off);
        w.code            = 16'($urandom);
        return w;
    endfunction

    // unused fields of a lookup word carry noise
    function automatic csgl_pkg::in_word_t make_lookup(input logic [15:0] code);
        csgl_pkg::in_word_t w;
        w                 = '0;
        w.op              = csgl_pkg::OP_LOOKUP;
        w.seg_index       = 6'($urandom);
        w.end_code        = 16'($urandom);
        w.start_code      = 16'($urandom);
        w.id_delta        = 16'($urandom);
        w.id_range_offset = 16'($urandom);
        w.code            = code;
        return w;
    endfunction

    // codes on or next to segment edges, inside segments, at the code space ends, or random
    function automatic logic [15:0] pick_code();
        int          j;
        logic [15:0] c;
        j = $urandom_range(0, csgl_pkg::SEG_MAX - 1);
        case ($urandom_range(0, 9))
            0, 1: c = 16'($urandom);
            2:    c = seg_end[j];
            3:    c = seg_end[j] + 16'd1;
            4:    c = seg_start[j];
            5:    c = seg_start[j] - 16'd1;
            6:    c = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
            default:
            begin
                if (seg_end[j] >= seg_start[j])
                    c = 16'($urandom_range(seg_start[j], seg_end[j]));
                else
                    c = seg_start[j];
            end
        endcase
        return c;
    endfunction

    task automatic send_word(input csgl_pkg::in_word_t w);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 2) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (w.op == csgl_pkg::OP_WRITE)
        begin
            seg_end[w.seg_index]      = w.end_code;
            seg_start[w.seg_index]    = w.start_code;
            seg_delta[w.seg_index]    = w.id_delta;
            seg_indirect[w.seg_index] = (w.id_range_offset != 16'd0);
        end
        else
            expected_glyphs = {expected_glyphs, predict_glyph(w.code)};
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_glyphs.size() != 0)
            @(posedge clk);
        // a trailing write word may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_segment_count(input logic [6:0] count);
        wait_drained();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(negedge clk);
        cfg_we    <= 1'b0;
        seg_count = count;
    endtask

    // ascending end codes, mostly contiguous, some holes, some indirect segments
    task automatic load_sorted_table();
        int prev_end;
        int e;
        int s;
        int off;
        prev_end = -1;
        for (int i = 0; i < csgl_pkg::SEG_MAX; i++)
        begin
            if ($urandom_range(0, 7) == 0)
                e = prev_end + $urandom_range(0, 4000);
            else
                e = prev_end + $urandom_range(1, 1500);
            if (i == csgl_pkg::SEG_MAX - 1 && $urandom_range(0, 1) == 1)
                e = 65535;
            if (e > 65535)
                e = 65535;
            if (e < 0)
                e = 0;
            case ($urandom_range(0, 7))
                0: s = $urandom_range(0, 65535);
                1: s = (e > prev_end) ? prev_end + 1 + $urandom_range(0, e - prev_end - 1)
                                      : prev_end + 1;
                default: s = prev_end + 1;
            endcase
            if (s > 65535)
                s = 65535;
            off = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535) : 0;
            send_word(make_write(i, e, s, $urandom_range(0, 65535), off));
            prev_end = e;
        end
    endtask

    task automatic run_traffic(input int words, input bit vary_idle);
        int r;
        int j;
        for (int k = 0; k < words; k++)
        begin
            if (vary_idle && k % 40 == 0)
            begin
                gaps_on   = ($urandom_range(0, 2) != 0);
                stalls_on = ($urandom_range(0, 2) != 0);
            end
            r = $urandom_range(0, 19);
            j = $urandom_range(0, csgl_pkg::SEG_MAX - 1);
            if (r < 14)
                send_word(make_lookup(pick_code()));
            else if (r < 17)
                // keep the range, change only the mapping of the entry
                send_word(make_write(j, seg_end[j], seg_start[j], $urandom_range(0, 65535),
                                     $urandom_range(0, 1) ? 0 : $urandom_range(0, 65535)));
            else
                send_word(make_write(j, $urandom_range(0, 65535), $urandom_range(0, 65535),
                                     $urandom_range(0, 65535), $urandom_range(0, 65535)));
        end
    endtask

    task automatic test_directed();
        set_segment_count(7'd0);
        send_word(make_lookup(16'h0000));
        send_word(make_lookup(16'hFFFF));
        send_word(make_write(0,  16'h0010, 16'h0000, 16'hFFFF, 16'h0000));
        send_word(make_write(1,  16'h0100, 16'h0080, 16'h0005, 16'hFFFF));
        send_word(make_write(2,  16'h8000, 16'h0101, 16'h1234, 16'h0000));
        send_word(make_write(3,  16'hFFFE, 16'hFFF0, 16'h0001, 16'h0001));
        send_word(make_write(63, 16'hFFFF, 16'h0000, 16'hABCD, 16'h8000));
        set_segment_count(7'd4);
        send_word(make_lookup(16'h0000));
        send_word(make_lookup(16'h0010));   // delta wraps
        send_word(make_lookup(16'h0011));   // hole below start
        send_word(make_lookup(16'h007F));
        send_word(make_lookup(16'h0080));   // indirect
        send_word(make_lookup(16'h0100));
        send_word(make_lookup(16'h0101));
        send_word(make_lookup(16'h8000));
        send_word(make_lookup(16'h8001));
        send_word(make_lookup(16'hFFEF));
        send_word(make_lookup(16'hFFF0));
        send_word(make_lookup(16'hFFFE));
        send_word(make_lookup(16'hFFFF));   // past every end code in the scanned segments
    endtask

    task automatic test_full_table();
        load_sorted_table();
        set_segment_count(7'd64);
        run_traffic(200, 1'b1);
    endtask

    task automatic test_count_saturation();
        set_segment_count(7'd127);
        run_traffic(150, 1'b1);
        set_segment_count(7'd65);
        run_traffic(100, 1'b1);
    endtask

    task automatic test_short_counts();
        set_segment_count(7'd1);
        run_traffic(100, 1'b1);
        set_segment_count(7'd0);
        run_traffic(60, 1'b1);
        load_sorted_table();
        set_segment_count(7'($urandom_range(2, 63)));
        run_traffic(120, 1'b1);
    endtask

    task automatic test_drain_pause();
        set_segment_count(7'd64);
        run_traffic(60, 1'b1);
        wait_drained();
        run_traffic(60, 1'b1);
    endtask

    task automatic test_steady_stream();
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        load_sorted_table();
        set_segment_count(7'd64);
        run_traffic(180, 1'b0);
    endtask

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (rst_n && stalls_on && $urandom_range(0, 3) == 0)
        begin
            stall_left <= $urandom_range(0, 2);
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    task automatic report_mismatch(input string field, input int want, input int got);
        fail_count++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_glyphs.size() == 0)
            begin
                fail_count++;
                $display("%0t: result word with none expected, actual %h",
                         $time, out_word);
            end
            else
            begin
                glyph_want = expected_glyphs.pop_front();
                if (out_word.glyph_index !== glyph_want.glyph_index)
                    report_mismatch("glyph_index", glyph_want.glyph_index,
                                    out_word.glyph_index);
                if (out_word.status !== glyph_want.status)
                    report_mismatch("status", glyph_want.status, out_word.status);
                if (out_word.matched_segment !== glyph_want.matched_segment)
                    report_mismatch("matched_segment", glyph_want.matched_segment,
                                    out_word.matched_segment);
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        in_word   = '0;
        seg_count = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_full_table();
        test_count_saturation();
        test_short_counts();
        test_drain_pause();
        test_steady_stream();
        wait_drained();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
